>>> rtl/tcf_pkg.sv
`default_nettype none

package tcf_pkg;

  localparam int SAMPLE_BITS  = 12;
  localparam int MEDIAN_TAPS  = 5;
  localparam int AVERAGE_TAPS = 4;

  localparam logic [SAMPLE_BITS-1:0] MAX_JUMP_RESET = SAMPLE_BITS'(400);

  // median window indexing
  localparam int MED_IDX_W = (MEDIAN_TAPS > 1) ? $clog2(MEDIAN_TAPS) : 1;
  localparam int MED_CNT_W = $clog2(MEDIAN_TAPS + 1);
  localparam int MED_MID   = MEDIAN_TAPS / 2;

  // average window indexing and divide-by-fill reciprocal
  localparam int AVG_IDX_W = (AVERAGE_TAPS > 1) ? $clog2(AVERAGE_TAPS) : 1;
  localparam int AVG_CNT_W = $clog2(AVERAGE_TAPS + 1);
  localparam int SUM_W     = SAMPLE_BITS + $clog2(AVERAGE_TAPS);
  localparam int DIV_SHIFT = SUM_W + AVG_CNT_W;
  localparam int RECIP_W   = DIV_SHIFT + 1;
  localparam int PROD_W    = SUM_W + RECIP_W;

  // stream packing
  localparam int TDATA_W    = ((2 * SAMPLE_BITS + 7) / 8) * 8;
  localparam int IN_TUSER_W = 2;
  localparam int TU_VALID   = 0;
  localparam int TU_PEN     = 1;

  typedef struct packed {
    logic start;   // run one sample through the filter chain
    logic reseed;  // clear windows and clamp history first
  } lane_cmd_t;

  typedef struct packed {
    logic req;     // an event is waiting to go out
    logic check;   // drop it if the position did not change
    logic pen;     // pen state carried with the event
  } emit_t;

endpackage

`default_nettype wire

>>> rtl/tcf_axis.sv
`default_nettype none

module tcf_axis (
  input  wire                                   clk,
  input  wire                                   rst,
  input  wire  tcf_pkg::lane_cmd_t              cmd,
  input  wire  logic [tcf_pkg::SAMPLE_BITS-1:0] max_jump,
  input  wire  logic [tcf_pkg::SAMPLE_BITS-1:0] sample,
  output logic                                  busy,
  output logic                                  done,
  output logic [tcf_pkg::SAMPLE_BITS-1:0]       filtered
);

  localparam int SB   = tcf_pkg::SAMPLE_BITS;
  localparam int MT   = tcf_pkg::MEDIAN_TAPS;
  localparam int AT   = tcf_pkg::AVERAGE_TAPS;
  localparam int MIW  = tcf_pkg::MED_IDX_W;
  localparam int MCW  = tcf_pkg::MED_CNT_W;
  localparam int AIW  = tcf_pkg::AVG_IDX_W;
  localparam int ACW  = tcf_pkg::AVG_CNT_W;
  localparam int LIMW = MCW + 1;

  // stage flags: window written, median held, average written, sum held, product held
  logic [4:0] stg;

  logic [SB-1:0]  last_acc;
  logic           seeded;
  logic [SB-1:0]  med_win [MT];
  logic [MCW-1:0] med_fill;
  logic [MIW-1:0] med_pos;
  logic [SB-1:0]  med_q;
  logic [SB-1:0]  avg_win [AT];
  logic [ACW-1:0] avg_fill;
  logic [AIW-1:0] avg_pos;
  logic [tcf_pkg::SUM_W-1:0]  sum_q;
  logic [tcf_pkg::PROD_W-1:0] prod_q;

  // clamp against the last accepted sample
  logic [SB-1:0]  diff;
  logic [SB-1:0]  clamped;
  logic [MIW-1:0] med_pos_eff;
  logic [MCW-1:0] med_fill_eff;

  always_comb begin
    diff         = (sample > last_acc) ? sample - last_acc : last_acc - sample;
    clamped      = (seeded && !cmd.reseed && diff > max_jump) ? last_acc : sample;
    med_pos_eff  = cmd.reseed ? '0 : med_pos;
    med_fill_eff = cmd.reseed ? '0 : med_fill;
  end

  // median: pad unfilled taps low and high so the middle tap of a full
  // sort equals the upper middle of the filled taps
  logic [LIMW-1:0] fill_x;
  logic [LIMW-1:0] pad_lim;
  logic [SB-1:0]   srt [MT];
  logic [SB-1:0]   tmp;

  always_comb begin
    fill_x  = {1'b0, med_fill};
    pad_lim = fill_x + LIMW'(tcf_pkg::MED_MID) - (fill_x >> 1);
    for (int i = 0; i < MT; i++) begin
      if (LIMW'(i) < fill_x) begin
        srt[i] = med_win[i];
      end else if (LIMW'(i) < pad_lim) begin
        srt[i] = '0;
      end else begin
        srt[i] = '1;
      end
    end
    tmp = '0;
    // odd-even transposition sort
    for (int st = 0; st < MT; st++) begin
      for (int i = (st & 1); i + 1 < MT; i += 2) begin
        if (srt[i] > srt[i+1]) begin
          tmp      = srt[i];
          srt[i]   = srt[i+1];
          srt[i+1] = tmp;
        end
      end
    end
  end

  // sum of the filled average taps
  logic [tcf_pkg::SUM_W-1:0] sum_next;

  always_comb begin
    sum_next = '0;
    for (int i = 0; i < AT; i++) begin
      if (ACW'(i) < avg_fill) begin
        sum_next = sum_next + tcf_pkg::SUM_W'(avg_win[i]);
      end
    end
  end

  // reciprocal of each possible fill count
  logic [tcf_pkg::RECIP_W-1:0] recip_tab [AT];

  for (genvar Div = 1; Div <= AT; Div++) begin : g_recip
    localparam longint unsigned Rc =
      ((longint'(1) << tcf_pkg::DIV_SHIFT) + longint'(Div) - 1) / longint'(Div);
    assign recip_tab[Div-1] = tcf_pkg::RECIP_W'(Rc);
  end

  logic [ACW-1:0] fill_m1;
  assign fill_m1 = avg_fill - 1'b1;

  // payload storage
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      med_win[med_pos_eff] <= clamped;
    end
    if (stg[0]) begin
      med_q <= srt[tcf_pkg::MED_MID];
    end
    if (stg[1]) begin
      avg_win[avg_pos] <= med_q;
    end
    if (stg[2]) begin
      sum_q <= sum_next;
    end
    if (stg[3]) begin
      prod_q <= tcf_pkg::PROD_W'(sum_q) * tcf_pkg::PROD_W'(recip_tab[fill_m1[AIW-1:0]]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stg      <= '0;
      last_acc <= '0;
      seeded   <= 1'b0;
      med_fill <= '0;
      med_pos  <= '0;
      avg_fill <= '0;
      avg_pos  <= '0;
      filtered <= '0;
    end else begin
      stg <= {stg[3:0], cmd.start};
      if (cmd.reseed) begin
        seeded   <= 1'b0;
        med_fill <= '0;
        med_pos  <= '0;
        avg_fill <= '0;
        avg_pos  <= '0;
      end
      if (cmd.start) begin
        last_acc <= clamped;
        seeded   <= 1'b1;
        med_pos  <= (med_pos_eff == MIW'(MT - 1)) ? '0 : med_pos_eff + 1'b1;
        med_fill <= (med_fill_eff == MCW'(MT)) ? med_fill_eff : med_fill_eff + 1'b1;
      end
      if (stg[1]) begin
        avg_pos  <= (avg_pos == AIW'(AT - 1)) ? '0 : avg_pos + 1'b1;
        avg_fill <= (avg_fill == ACW'(AT)) ? avg_fill : avg_fill + 1'b1;
      end
      if (stg[4]) begin
        filtered <= prod_q[tcf_pkg::DIV_SHIFT +: SB];
      end
    end
  end

  assign busy = |stg;
  assign done = stg[4];

endmodule

`default_nettype wire

>>> rtl/tcf_merge.sv
`default_nettype none

module tcf_merge (
  input  wire                                   clk,
  input  wire                                   rst,
  input  wire  tcf_pkg::emit_t                  emit,
  input  wire  logic [tcf_pkg::SAMPLE_BITS-1:0] x_new,
  input  wire  logic [tcf_pkg::SAMPLE_BITS-1:0] y_new,
  input  wire  logic [tcf_pkg::SAMPLE_BITS-1:0] x_prev,
  input  wire  logic [tcf_pkg::SAMPLE_BITS-1:0] y_prev,
  output logic                                  emit_done,
  output logic                                  m_axis_tvalid,
  input  wire                                   m_axis_tready,
  output logic [tcf_pkg::TDATA_W-1:0]           m_axis_tdata,  // x_filtered, y_filtered
  output logic                                  m_axis_tuser   // pen_state
);

  logic same;
  logic free;
  logic load;

  assign same      = emit.check && (x_new == x_prev) && (y_new == y_prev);
  assign free      = !m_axis_tvalid || m_axis_tready;
  assign load      = emit.req && !same && free;
  assign emit_done = emit.req && (same || free);

  always_ff @(posedge clk) begin
    if (load) begin
      m_axis_tdata <= tcf_pkg::TDATA_W'({y_new, x_new});
      m_axis_tuser <= emit.pen;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

>>> rtl/touch_coordinate_filter.sv
// Samples are taken one at a time: a pen-pressed sample runs through the six-step
// axis lane chain (clamp, median sort, average write, sum, reciprocal multiply,
// scale) and then the output load, and no new sample is accepted until that event
// has gone to the master side or been dropped, so a stall there holds the input;
// a release goes straight to the output load, and an ignored sample is discarded.
// Reset (rst, synchronous, high) clears pen state, fill counts and max_jump to 400.
`default_nettype none

module touch_coordinate_filter (
  input  wire                                   clk,
  input  wire                                   rst,
  input  wire                                   cfg_we,
  input  wire  logic [tcf_pkg::SAMPLE_BITS-1:0] cfg_data,
  input  wire                                   s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  wire  logic [tcf_pkg::TDATA_W-1:0]     s_axis_tdata,  // x_raw, y_raw
  input  wire  logic [tcf_pkg::IN_TUSER_W-1:0]  s_axis_tuser,  // sample_valid, pen_pressed
  output logic                                  m_axis_tvalid,
  input  wire                                   m_axis_tready,
  output logic [tcf_pkg::TDATA_W-1:0]           m_axis_tdata,  // x_filtered, y_filtered
  output logic                                  m_axis_tuser   // pen_state
);

  localparam int SB = tcf_pkg::SAMPLE_BITS;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_EMIT = 3'b100
  } state_t;

  state_t         state;
  logic           pen_down;
  logic [SB-1:0]  max_jump;
  logic [SB-1:0]  x_prev;
  logic [SB-1:0]  y_prev;
  logic           emit_check;
  logic           emit_pen;

  logic               acc;
  logic               smp_valid;
  logic               smp_pen;
  tcf_pkg::lane_cmd_t cmd;
  tcf_pkg::emit_t     emit;
  logic               emit_done;
  logic               x_busy, y_busy;
  logic               x_done, y_done;
  logic [SB-1:0]      x_filt, y_filt;

  assign s_axis_tready = (state == S_IDLE);
  assign acc           = s_axis_tvalid && s_axis_tready;
  assign smp_valid     = s_axis_tuser[tcf_pkg::TU_VALID];
  assign smp_pen       = s_axis_tuser[tcf_pkg::TU_PEN];

  always_comb begin
    cmd.start  = acc && smp_valid && smp_pen;
    cmd.reseed = acc && smp_valid && (smp_pen ? !pen_down : pen_down);
  end

  tcf_axis u_x (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .max_jump (max_jump),
    .sample   (s_axis_tdata[SB-1:0]),
    .busy     (x_busy),
    .done     (x_done),
    .filtered (x_filt)
  );

  tcf_axis u_y (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .max_jump (max_jump),
    .sample   (s_axis_tdata[2*SB-1:SB]),
    .busy     (y_busy),
    .done     (y_done),
    .filtered (y_filt)
  );

  always_comb begin
    emit.req   = (state == S_EMIT);
    emit.check = emit_check;
    emit.pen   = emit_pen;
  end

  tcf_merge u_merge (
    .clk           (clk),
    .rst           (rst),
    .emit          (emit),
    .x_new         (x_filt),
    .y_new         (y_filt),
    .x_prev        (x_prev),
    .y_prev        (y_prev),
    .emit_done     (emit_done),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // hold the position seen before a move so the merge can drop unchanged ones
  always_ff @(posedge clk) begin
    if (acc) begin
      x_prev     <= x_filt;
      y_prev     <= y_filt;
      emit_check <= smp_pen && pen_down;
      emit_pen   <= smp_pen;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      pen_down <= 1'b0;
      max_jump <= tcf_pkg::MAX_JUMP_RESET;
    end else begin
      if (cfg_we) begin
        max_jump <= cfg_data;
      end
      unique case (state)
        S_IDLE: begin
          if (acc && smp_valid) begin
            if (smp_pen) begin
              pen_down <= 1'b1;
              state    <= S_RUN;
            end else if (pen_down) begin
              pen_down <= 1'b0;
              state    <= S_EMIT;
            end
          end
        end
        S_RUN: begin
          if (x_done) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (emit_done) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_idle_lanes: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> (!x_busy && !y_busy))
    else $error("input ready while a lane is still working");

  a_lockstep: assert property (@(posedge clk) disable iff (rst)
    (x_done == y_done) && (x_busy == y_busy))
    else $error("axis lanes out of step");

  a_press_runs: assert property (@(posedge clk) disable iff (rst)
    (acc && smp_valid && smp_pen) |=> (state == S_RUN))
    else $error("pressed sample did not start the lanes");

endmodule

`default_nettype wire
